>>> design/mpe_pkg.sv
// Shared constants, types and codes of the matrix product engine.
package mpe_pkg;

  localparam int MAX_SIZE   = 64;
  localparam int ELEM_WIDTH = 16;

  localparam int IDX_W   = $clog2(MAX_SIZE);
  localparam int CNT_W   = $clog2(MAX_SIZE + 1);
  localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROD_W  = 2 * ELEM_WIDTH;

  localparam int ACTION_W = 2;
  localparam int POS_W    = 6;
  localparam int VALUE_W  = 16;
  localparam int ACC_W    = 38;
  localparam int SIZE_W   = 7;

  typedef logic [ACTION_W-1:0]       action_t;
  typedef logic [POS_W-1:0]          pos_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic [SIZE_W-1:0]         size_t;
  typedef logic signed [ELEM_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [ADDR_W-1:0]         addr_t;
  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  localparam action_t ACT_LOAD_A = 2'd0;
  localparam action_t ACT_LOAD_B = 2'd1;
  localparam action_t ACT_READ   = 2'd2;

  localparam size_t SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

endpackage

>>> design/mpe_if.sv
// Valid/ready channels for input words and result words.
interface mpe_in_if;
  logic              valid;
  logic              ready;
  mpe_pkg::action_t  action;
  mpe_pkg::pos_t     row;
  mpe_pkg::pos_t     col;
  mpe_pkg::value_t   value;

  modport source (output valid, action, row, col, value, input ready);
  modport sink   (input valid, action, row, col, value, output ready);
endinterface

interface mpe_out_if;
  logic            valid;
  logic            ready;
  mpe_pkg::pos_t   out_row;
  mpe_pkg::pos_t   out_col;
  mpe_pkg::acc_t   product;

  modport source (output valid, out_row, out_col, product, input ready);
  modport sink   (input valid, out_row, out_col, product, output ready);
endinterface

>>> design/mpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/matrix_product_engine.sv
// Top level of the matrix product engine: element stores, sequencer and shared MAC.
//
// Load words (action 0 for A, 1 for B) write one element into the A or B store
// in the cycle they are accepted and give no result; action 3 is dropped. A read
// word (action 2) returns element (row, col) of C = A x B, the exact signed dot
// product of row `row` of A and column `col` of B over matrix_size terms
// (0 acts as 1, values above 64 act as 64), wrapped to 38 bits. A read runs
// one multiply-accumulate per cycle through a single 16x16 multiplier and 38-bit
// adder, fed by one read port on each store, and passes the RAM read, multiply
// and accumulate registers before the result goes to the output register.
// in_ch.ready is low while a read is in work. The output register frees the
// input side: loads are taken while a result waits. Stores are not cleared at
// reset; read only elements already loaded.
module matrix_product_engine (
  input  logic                 clk,
  input  logic                 rst_n,
  mpe_in_if.sink               in_ch,
  mpe_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  mpe_pkg::size_t       cfg_wdata
);

  mpe_pkg::state_t state_r, state_nxt;
  mpe_pkg::size_t  size_r;

  mpe_pkg::pos_t   row_r, col_r;
  mpe_pkg::addr_t  a_addr_r, b_addr_r;
  mpe_pkg::idx_t   cnt_r, last_r;
  logic            rd_v_r, mul_v_r;
  mpe_pkg::prod_t  mul_r;
  mpe_pkg::acc_t   acc_r;

  logic            out_valid_r;
  mpe_pkg::pos_t   out_row_r, out_col_r;
  mpe_pkg::acc_t   product_r;

  logic            in_ready, issue, out_load, pipe_empty;
  logic            in_fire, rd_fire, in_range;
  mpe_pkg::cnt_t   eff_size;
  mpe_pkg::idx_t   last_idx;
  mpe_pkg::elem_t  wr_elem;
  mpe_pkg::addr_t  wr_addr;
  logic            we_a, we_b;
  logic [mpe_pkg::ELEM_WIDTH-1:0] rd_a, rd_b;

  assign in_fire  = in_ch.valid && in_ready;
  assign rd_fire  = in_fire && (in_ch.action == mpe_pkg::ACT_READ);
  assign in_range = (32'(in_ch.row) < mpe_pkg::MAX_SIZE) &&
                    (32'(in_ch.col) < mpe_pkg::MAX_SIZE);
  assign wr_elem  = mpe_pkg::ELEM_WIDTH'(in_ch.value);
  assign wr_addr  = mpe_pkg::ADDR_W'(32'(in_ch.row) * mpe_pkg::MAX_SIZE + 32'(in_ch.col));
  assign we_a     = in_fire && in_range && (in_ch.action == mpe_pkg::ACT_LOAD_A);
  assign we_b     = in_fire && in_range && (in_ch.action == mpe_pkg::ACT_LOAD_B);

  always_comb begin
    if (size_r == '0) begin
      eff_size = mpe_pkg::CNT_W'(1);
    end else if (32'(size_r) > mpe_pkg::MAX_SIZE) begin
      eff_size = mpe_pkg::CNT_W'(mpe_pkg::MAX_SIZE);
    end else begin
      eff_size = mpe_pkg::CNT_W'(size_r);
    end
    last_idx = mpe_pkg::IDX_W'(eff_size - mpe_pkg::CNT_W'(1));
  end

  mpe_ram #(
    .WIDTH (mpe_pkg::ELEM_WIDTH),
    .DEPTH (mpe_pkg::DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (a_addr_r),
    .rdata (rd_a)
  );

  mpe_ram #(
    .WIDTH (mpe_pkg::ELEM_WIDTH),
    .DEPTH (mpe_pkg::DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .raddr (b_addr_r),
    .rdata (rd_b)
  );

  always_comb begin
    pipe_empty = !rd_v_r && !mul_v_r;
    in_ready   = (state_r == mpe_pkg::ST_IDLE);
    issue      = (state_r == mpe_pkg::ST_RUN);
    out_load   = (state_r == mpe_pkg::ST_DRAIN) && pipe_empty &&
                 (!out_valid_r || out_ch.ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpe_pkg::ST_IDLE: begin
        if (rd_fire) begin
          state_nxt = in_range ? mpe_pkg::ST_RUN : mpe_pkg::ST_DRAIN;
        end
      end
      mpe_pkg::ST_RUN: begin
        if (cnt_r == last_r) begin
          state_nxt = mpe_pkg::ST_DRAIN;
        end
      end
      mpe_pkg::ST_DRAIN: begin
        if (out_load) begin
          state_nxt = mpe_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpe_pkg::ST_IDLE;
      size_r      <= mpe_pkg::SIZE_RESET;
      rd_v_r      <= 1'b0;
      mul_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= issue;
      mul_v_r <= rd_v_r;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_fire) begin
      row_r    <= in_ch.row;
      col_r    <= in_ch.col;
      a_addr_r <= mpe_pkg::ADDR_W'(32'(in_ch.row) * mpe_pkg::MAX_SIZE);
      b_addr_r <= mpe_pkg::ADDR_W'(in_ch.col);
      cnt_r    <= '0;
      last_r   <= last_idx;
    end else if (issue) begin
      a_addr_r <= a_addr_r + mpe_pkg::ADDR_W'(1);
      b_addr_r <= b_addr_r + mpe_pkg::ADDR_W'(mpe_pkg::MAX_SIZE);
      cnt_r    <= cnt_r + mpe_pkg::IDX_W'(1);
    end
    mul_r <= $signed(rd_a) * $signed(rd_b);
    if (rd_fire) begin
      acc_r <= '0;
    end else if (mul_v_r) begin
      acc_r <= acc_r + mpe_pkg::ACC_W'(mul_r);
    end
    if (out_load) begin
      out_row_r <= row_r;
      out_col_r <= col_r;
      product_r <= acc_r;
    end
  end

  assign in_ch.ready    = in_ready;
  assign out_ch.valid   = out_valid_r;
  assign out_ch.out_row = out_row_r;
  assign out_ch.out_col = out_col_r;
  assign out_ch.product = product_r;

  a_idle_pipe_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpe_pkg::ST_IDLE) |-> (!rd_v_r && !mul_v_r))
    else $error("MAC pipeline busy while idle");

  a_load_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ch.ready))
    else $error("result overwrites pending word");

  a_read_leaves_idle : assert property (@(posedge clk) disable iff (!rst_n)
    rd_fire |=> (state_r != mpe_pkg::ST_IDLE))
    else $error("read word accepted without starting");

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mpe_pkg::ST_RUN) |-> (cnt_r <= last_r))
    else $error("MAC index beyond size");

endmodule
